[hdl/gjk_pkg.sv]
// ----------------------------------------------------------------------------
// GJK overlap package
// Shared widths, op codes, status codes, states and the scan token type.
// ----------------------------------------------------------------------------
package gjk_pkg;

  localparam int unsigned DirW = 32;
  localparam int unsigned PtW  = 18;
  localparam int unsigned ProjW = 60;

  typedef enum logic [1:0] {
    OP_ADD_A = 2'd0,
    OP_ADD_B = 2'd1,
    OP_CLEAR = 2'd2,
    OP_TEST  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DECIDED  = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_LIMIT    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_DIR, S_SCAN, S_CHECK, S_MUL1, S_MUL2, S_DECIDE, S_OUT
  } state_e;

  // token passed down the cell chain during a support scan
  typedef struct packed {
    logic                    valid;
    logic                    has_a;
    logic                    has_b;
    logic signed [ProjW-1:0] best_a;
    logic signed [ProjW-1:0] best_b;
    logic signed [15:0]      ax;
    logic signed [15:0]      ay;
    logic signed [15:0]      bx;
    logic signed [15:0]      by;
  } scan_t;

endpackage

[hdl/gjk_cell.sv]
// ----------------------------------------------------------------------------
// GJK vertex cell
// Holds one vertex of A and one of B, keeps the best support of the token.
// ----------------------------------------------------------------------------
module gjk_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_a_i,
  input  logic                            wr_b_i,
  input  logic signed [15:0]              wx_i,
  input  logic signed [15:0]              wy_i,
  input  logic                            use_a_i,
  input  logic                            use_b_i,
  input  logic signed [gjk_pkg::DirW-1:0] dx_i,
  input  logic signed [gjk_pkg::DirW-1:0] dy_i,
  input  gjk_pkg::scan_t                  tok_i,
  output gjk_pkg::scan_t                  tok_o
);
  logic signed [15:0] ax_q, ay_q, bx_q, by_q;
  logic signed [gjk_pkg::ProjW-1:0] pa, pb;
  gjk_pkg::scan_t tok_d, tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_a_i) begin
      ax_q <= wx_i;
      ay_q <= wy_i;
    end
    if (wr_b_i) begin
      bx_q <= wx_i;
      by_q <= wy_i;
    end
  end

  // A along d, B along -d
  assign pa = gjk_pkg::ProjW'(ax_q * dx_i) + gjk_pkg::ProjW'(ay_q * dy_i);
  assign pb = -(gjk_pkg::ProjW'(bx_q * dx_i) + gjk_pkg::ProjW'(by_q * dy_i));

  always_comb begin
    tok_d = tok_i;
    if (use_a_i && (!tok_i.has_a || pa > tok_i.best_a)) begin
      tok_d.has_a  = 1'b1;
      tok_d.best_a = pa;
      tok_d.ax     = ax_q;
      tok_d.ay     = ay_q;
    end
    if (use_b_i && (!tok_i.has_b || pb > tok_i.best_b)) begin
      tok_d.has_b  = 1'b1;
      tok_d.best_b = pb;
      tok_d.bx     = bx_q;
      tok_d.by     = by_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
endmodule

[hdl/gjk_convex_polygon_overlap_2d.sv]
// ----------------------------------------------------------------------------
// GJK convex polygon overlap, 2D
// Loads two vertex sets into a chain of cells and runs a GJK overlap test.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid_i, in_ready_o, op_i, vertex_x_i, vertex_y_i
// out     | output    | out_valid_o, out_ready_i, overlap_o, status_o
// cfg     | input     | cfg_we_i, cfg_wdata_i
// Load and clear items are done without leaving idle.
// A test sums the vertices and forms the direction, then runs one support scan
// before the rounds; each round runs a support scan, then the check and simplex
// update, and the result is posted at the end.
// Reset clears counts and flags and sets the limit register to 32; no clearing pass.
// A waiting result stalls the input until transferred.
module gjk_convex_polygon_overlap_2d #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned COORD_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic signed [15:0] vertex_x_i,
  input  logic signed [15:0] vertex_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        overlap_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned IdxW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned DirW = gjk_pkg::DirW;
  localparam int unsigned PtW  = gjk_pkg::PtW;
  localparam int unsigned MW   = 2 * DirW;

  gjk_pkg::state_e state_q, state_d;

  logic [7:0]      limit_q;
  logic [CntW-1:0] cnt_a_q, cnt_b_q;
  logic            ovf_q;
  logic [CntW-1:0] idx_q;
  logic [7:0]      rounds_q;
  logic            first_q;
  logic [1:0]      scount_q;
  logic signed [PtW-1:0] s0x_q, s0y_q, s1x_q, s1y_q, s2x_q, s2y_q;
  logic signed [DirW-1:0] dx_q, dy_q;
  logic signed [DirW-1:0] sax_q, say_q, sbx_q, sby_q;
  logic signed [MW-1:0]   m0_q, m1_q;
  logic signed [MW-1:0]   np_q;
  logic                   ov_q;
  logic [1:0]             st_q;
  logic                   out_v_q;

  logic signed [15:0] cx, cy;
  assign cx = 16'(signed'(vertex_x_i[COORD_BITS-1:0]));
  assign cy = 16'(signed'(vertex_y_i[COORD_BITS-1:0]));

  logic accept;
  assign in_ready_o = (state_q == gjk_pkg::S_IDLE) && !out_v_q;
  assign accept = in_valid_i && in_ready_o;

  // cell chain
  gjk_pkg::scan_t tok [MAX_VERTICES+1];
  assign tok[0] = '{valid: (state_q == gjk_pkg::S_SCAN) && idx_q == '0, default: '0};

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    logic wa, wb;
    assign wa = accept && op_i == gjk_pkg::OP_ADD_A && cnt_a_q == CntW'(g);
    assign wb = accept && op_i == gjk_pkg::OP_ADD_B && cnt_b_q == CntW'(g);
    gjk_cell u_cell (
      .clk_i, .rst_ni,
      .wr_a_i (wa), .wr_b_i (wb), .wx_i (cx), .wy_i (cy),
      .use_a_i (cnt_a_q > CntW'(g)), .use_b_i (cnt_b_q > CntW'(g)),
      .dx_i (dx_q), .dy_i (dy_q),
      .tok_i (tok[g]), .tok_o (tok[g+1])
    );
  end

  // sum read uses a separate small copy of the vertices
  logic signed [15:0] va_x_q [MAX_VERTICES];
  logic signed [15:0] va_y_q [MAX_VERTICES];
  logic signed [15:0] vb_x_q [MAX_VERTICES];
  logic signed [15:0] vb_y_q [MAX_VERTICES];
  always_ff @(posedge clk_i) begin
    if (accept && op_i == gjk_pkg::OP_ADD_A && cnt_a_q < CntW'(MAX_VERTICES)) begin
      va_x_q[cnt_a_q[IdxW-1:0]] <= cx;
      va_y_q[cnt_a_q[IdxW-1:0]] <= cy;
    end
    if (accept && op_i == gjk_pkg::OP_ADD_B && cnt_b_q < CntW'(MAX_VERTICES)) begin
      vb_x_q[cnt_b_q[IdxW-1:0]] <= cx;
      vb_y_q[cnt_b_q[IdxW-1:0]] <= cy;
    end
  end

  // support result
  gjk_pkg::scan_t fin;
  assign fin = tok[MAX_VERTICES];
  logic signed [PtW-1:0] px, py;
  assign px = PtW'(fin.ax) - PtW'(fin.bx);
  assign py = PtW'(fin.ay) - PtW'(fin.by);

  // shared multiplier operands
  logic signed [DirW-1:0] ma0, mb0, ma1, mb1;
  logic signed [PtW-1:0] ax, ay, bx, by, cxs, cys, abx, aby, acx, acy;
  always_comb begin
    if (scount_q == 2'd3) begin
      ax = s2x_q; ay = s2y_q; bx = s1x_q; by = s1y_q;
    end else begin
      ax = s1x_q; ay = s1y_q; bx = s0x_q; by = s0y_q;
    end
    cxs = s0x_q; cys = s0y_q;
    abx = bx - ax; aby = by - ay;
    acx = cxs - ax; acy = cys - ay;
  end

  logic signed [MW-1:0] prod0, prod1;
  always_comb begin
    ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0;
    case (state_q)
      gjk_pkg::S_DIR: begin
        ma0 = sax_q; mb0 = DirW'(cnt_b_q); ma1 = sbx_q; mb1 = DirW'(cnt_a_q);
      end
      gjk_pkg::S_CHECK: begin
        ma0 = DirW'(s2x_q); mb0 = dx_q; ma1 = DirW'(s2y_q); mb1 = dy_q;
        if (scount_q != 2'd3) begin
          ma0 = DirW'(scount_q == 2'd2 ? s1x_q : s0x_q);
          ma1 = DirW'(scount_q == 2'd2 ? s1y_q : s0y_q);
        end
      end
      gjk_pkg::S_MUL1: begin
        if (scount_q == 2'd3) begin
          ma0 = DirW'(abx); mb0 = DirW'(acy); ma1 = DirW'(aby); mb1 = DirW'(acx);
        end else begin
          ma0 = DirW'(abx); mb0 = DirW'(-ay); ma1 = DirW'(aby); mb1 = DirW'(-ax);
        end
      end
      gjk_pkg::S_MUL2: begin
        ma0 = DirW'(aby); mb0 = DirW'(-ax); ma1 = DirW'(abx); mb1 = DirW'(-ay);
      end
      gjk_pkg::S_DECIDE: begin
        ma0 = DirW'(acy); mb0 = DirW'(-ax); ma1 = DirW'(acx); mb1 = DirW'(-ay);
      end
      default: ;
    endcase
  end
  assign prod0 = ma0 * mb0;
  assign prod1 = ma1 * mb1;

  logic signed [1:0] sg;
  always_comb begin
    sg = 2'sd0;
    if (m0_q > m1_q) sg = 2'sd1;
    else if (m0_q < m1_q) sg = -2'sd1;
  end

  // triangle decision and round limit, valid in S_DECIDE
  logic np_pos, cp_pos, enclosed, give_up;
  assign np_pos   = (sg * np_q) > 0;
  assign cp_pos   = (sg * (prod1 - prod0)) > 0;
  assign enclosed = (scount_q == 2'd3) && !np_pos && !cp_pos;
  assign give_up  = !enclosed && (rounds_q >= limit_q);

  // next state
  logic at_end;
  assign at_end = idx_q == CntW'(MAX_VERTICES);
  always_comb begin
    state_d = state_q;
    case (state_q)
      gjk_pkg::S_IDLE:   if (accept && op_i == gjk_pkg::OP_TEST) begin
        if (ovf_q || cnt_a_q == '0 || cnt_b_q == '0) state_d = gjk_pkg::S_OUT;
        else state_d = gjk_pkg::S_SUM;
      end
      gjk_pkg::S_SUM:    if (at_end) state_d = gjk_pkg::S_DIR;
      gjk_pkg::S_DIR:    if (idx_q == CntW'(1)) state_d = gjk_pkg::S_SCAN;
      gjk_pkg::S_SCAN:   if (fin.valid) begin
        if (first_q) state_d = (limit_q == '0) ? gjk_pkg::S_OUT : gjk_pkg::S_SCAN;
        else state_d = gjk_pkg::S_CHECK;
      end
      gjk_pkg::S_CHECK:  state_d = gjk_pkg::S_MUL1;
      gjk_pkg::S_MUL1:   state_d = (idx_q == '0) ? gjk_pkg::S_OUT : gjk_pkg::S_MUL2;
      gjk_pkg::S_MUL2:   state_d = gjk_pkg::S_DECIDE;
      gjk_pkg::S_DECIDE: state_d = (enclosed || give_up) ? gjk_pkg::S_OUT : gjk_pkg::S_SCAN;
      gjk_pkg::S_OUT:    state_d = gjk_pkg::S_IDLE;
      default:           state_d = gjk_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gjk_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath and control registers
  logic signed [MW-1:0] dot;
  logic signed [MW-1:0] diff;
  assign dot  = prod0 + prod1;
  assign diff = prod0 - prod1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= 8'd32;
      cnt_a_q  <= '0;
      cnt_b_q  <= '0;
      ovf_q    <= 1'b0;
      idx_q    <= '0;
      rounds_q <= '0;
      first_q  <= 1'b0;
      scount_q <= '0;
      s0x_q    <= '0;
      s0y_q    <= '0;
      s1x_q    <= '0;
      s1y_q    <= '0;
      s2x_q    <= '0;
      s2y_q    <= '0;
      m0_q     <= '0;
      m1_q     <= '0;
      np_q     <= '0;
      out_v_q  <= 1'b0;
      ov_q     <= 1'b0;
      st_q     <= gjk_pkg::ST_DECIDED;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      case (state_q)
        gjk_pkg::S_IDLE: if (accept) begin
          case (op_i)
            gjk_pkg::OP_ADD_A: begin
              if (cnt_a_q < CntW'(MAX_VERTICES)) cnt_a_q <= cnt_a_q + 1'b1;
              else ovf_q <= 1'b1;
            end
            gjk_pkg::OP_ADD_B: begin
              if (cnt_b_q < CntW'(MAX_VERTICES)) cnt_b_q <= cnt_b_q + 1'b1;
              else ovf_q <= 1'b1;
            end
            gjk_pkg::OP_CLEAR: begin
              cnt_a_q <= '0; cnt_b_q <= '0; ovf_q <= 1'b0;
            end
            default: begin
              ov_q <= 1'b0;
              st_q <= ovf_q ? gjk_pkg::ST_OVERFLOW : gjk_pkg::ST_EMPTY;
              idx_q <= '0;
              rounds_q <= '0;
              first_q <= 1'b1;
              scount_q <= '0;
            end
          endcase
        end
        gjk_pkg::S_SUM: idx_q <= at_end ? '0 : idx_q + 1'b1;
        gjk_pkg::S_DIR: idx_q <= (idx_q == CntW'(1)) ? '0 : idx_q + 1'b1;
        gjk_pkg::S_SCAN: begin
          if (fin.valid) begin
            idx_q <= '0;
            if (scount_q == 2'd0) begin
              s0x_q <= px; s0y_q <= py;
            end else if (scount_q == 2'd1) begin
              s1x_q <= px; s1y_q <= py;
            end else begin
              s2x_q <= px; s2y_q <= py;
            end
            if (scount_q != 2'd3) scount_q <= scount_q + 1'b1;
            if (first_q) begin
              first_q <= 1'b0;
              st_q <= gjk_pkg::ST_LIMIT;
            end else begin
              rounds_q <= rounds_q + 1'b1;
            end
          end else if (!at_end) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        gjk_pkg::S_CHECK: begin
          idx_q <= (dot > 0) ? CntW'(1) : '0;
          if (!(dot > 0)) begin
            st_q <= gjk_pkg::ST_DECIDED;
            ov_q <= 1'b0;
          end
        end
        gjk_pkg::S_MUL1: begin
          m0_q <= prod0; m1_q <= prod1;
        end
        gjk_pkg::S_MUL2: np_q <= prod0 - prod1;
        gjk_pkg::S_DECIDE: begin
          idx_q <= '0;
          if (scount_q == 2'd3) begin
            if (np_pos) begin
              s0x_q <= bx; s0y_q <= by; s1x_q <= ax; s1y_q <= ay;
              scount_q <= 2'd2;
            end else if (cp_pos) begin
              s1x_q <= ax; s1y_q <= ay;
              scount_q <= 2'd2;
            end
          end
          if (enclosed) begin
            st_q <= gjk_pkg::ST_DECIDED;
            ov_q <= 1'b1;
          end else if (give_up) begin
            st_q <= gjk_pkg::ST_LIMIT;
            ov_q <= 1'b0;
          end
        end
        gjk_pkg::S_OUT: out_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // sums and search direction
  always_ff @(posedge clk_i) begin
    if (state_q == gjk_pkg::S_IDLE) begin
      sax_q <= '0; say_q <= '0; sbx_q <= '0; sby_q <= '0;
    end else if (state_q == gjk_pkg::S_SUM && !at_end) begin
      if (idx_q < cnt_a_q) begin
        sax_q <= sax_q + DirW'(va_x_q[idx_q[IdxW-1:0]]);
        say_q <= say_q + DirW'(va_y_q[idx_q[IdxW-1:0]]);
      end
      if (idx_q < cnt_b_q) begin
        sbx_q <= sbx_q + DirW'(vb_x_q[idx_q[IdxW-1:0]]);
        sby_q <= sby_q + DirW'(vb_y_q[idx_q[IdxW-1:0]]);
      end
    end
    if (state_q == gjk_pkg::S_DIR) begin
      if (idx_q == '0) begin
        dx_q <= DirW'(diff);
        sax_q <= say_q; sbx_q <= sby_q;
      end else begin
        dy_q <= DirW'(diff);
        if (dx_q == '0 && diff == '0) dx_q <= DirW'(1);
      end
    end else if (state_q == gjk_pkg::S_SCAN && fin.valid && first_q) begin
      dx_q <= -dx_q; dy_q <= -dy_q;
    end else if (state_q == gjk_pkg::S_DECIDE) begin
      if (scount_q != 2'd3) begin
        dx_q <= DirW'(-sg * aby); dy_q <= DirW'(sg * abx);
      end else if (np_pos) begin
        dx_q <= DirW'(sg * aby); dy_q <= DirW'(-sg * abx);
      end else if (cp_pos) begin
        dx_q <= DirW'(-sg * acy); dy_q <= DirW'(sg * acx);
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign overlap_o   = ov_q;
  assign status_o    = st_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == gjk_pkg::S_IDLE) else $error("ready outside idle");
  a_cnt_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_a_q <= CntW'(MAX_VERTICES)) else $error("count A too large");
  a_cnt_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_b_q <= CntW'(MAX_VERTICES)) else $error("count B too large");
  a_ov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && ov_q |-> st_q == gjk_pkg::ST_DECIDED) else $error("overlap with status");
`endif
endmodule
